### design/bczr_pkg.sv
// Package for the byte class zone regime detector.
// Holds the widths, byte codes, class and event codes and the result layout.
// No dependencies; every other design file imports it.
`default_nettype none

package bczr_pkg;

  // Number of byte classes counted per zone.
  localparam int NUM_CLASSES = 6;

  // Class positions in the per-class vectors and arrays.
  localparam int CLS_SPACE = 0;
  localparam int CLS_QUOTE = 1;
  localparam int CLS_BRACE = 2;
  localparam int CLS_COLON = 3;
  localparam int CLS_COMMA = 4;
  localparam int CLS_HIGH  = 5;

  // Byte codes of the classes.
  localparam logic [7:0] BYTE_SPACE       = 8'h20;
  localparam logic [7:0] BYTE_QUOTE       = 8'h22;
  localparam logic [7:0] BYTE_BRACE_OPEN  = 8'h7B;
  localparam logic [7:0] BYTE_BRACE_CLOSE = 8'h7D;
  localparam logic [7:0] BYTE_COLON       = 8'h3A;
  localparam logic [7:0] BYTE_COMMA       = 8'h2C;

  // Field widths.
  localparam int DATA_W      = 64;
  localparam int LANE_CNT_W  = 4;
  localparam int COUNT_W     = 33;
  localparam int ZONE_SIZE_W = 32;
  localparam int INDEX_W     = 32;
  localparam int OFFSET_W    = 64;
  localparam int PPM_W       = 20;
  localparam int DELTA_W     = 23;
  localparam int KIND_W      = 2;
  localparam int PROD_W      = COUNT_W + PPM_W;

  // Parts per million scale.
  localparam logic [PPM_W-1:0] PPM_SCALE = 20'd1000000;

  // Stream and configuration widths.
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 280;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 1;

  // Configuration register indexes and reset values.
  localparam logic [CFG_INDEX_W-1:0] REG_ZONE_SIZE       = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_EVENT_THRESHOLD = 1'b1;
  localparam logic [ZONE_SIZE_W-1:0] ZONE_SIZE_RST       = 32'd8388608;
  localparam logic [DELTA_W-1:0]     EVENT_THRESHOLD_RST = 23'd45000;

  // Event codes.
  localparam logic [KIND_W-1:0] EV_BOOT   = 2'd0;
  localparam logic [KIND_W-1:0] EV_REGIME = 2'd1;
  localparam logic [KIND_W-1:0] EV_STABLE = 2'd2;

  // One class hit flag per class, from one byte lane.
  typedef logic [NUM_CLASSES-1:0] class_flags_t;

  // Result item as it travels in m_tdata; zone_index sits in the lowest bits.
  typedef struct packed {
    logic [5:0]             pad;
    logic [KIND_W-1:0]      event_kind;
    logic [DELTA_W-1:0]     delta_ppm;
    logic [PPM_W-1:0]       high_bit_ppm;
    logic [PPM_W-1:0]       comma_ppm;
    logic [PPM_W-1:0]       colon_ppm;
    logic [PPM_W-1:0]       brace_ppm;
    logic [PPM_W-1:0]       quote_ppm;
    logic [PPM_W-1:0]       space_ppm;
    logic [COUNT_W-1:0]     zone_length;
    logic [OFFSET_W-1:0]    byte_offset;
    logic [INDEX_W-1:0]     zone_index;
  } out_item_t;

endpackage

`default_nettype wire

### design/bczr_lane.sv
// One byte lane: classifies a single byte into the six counted classes.
// Depends on bczr_pkg for the byte codes and the flag type.
`default_nettype none

module bczr_lane
  import bczr_pkg::*;
(
  input  wire logic [7:0]   lane_byte,
  input  wire logic         en,
  output class_flags_t      flags
);

  // A lane beyond the valid byte count raises no flag.
  always_comb begin
    flags = '0;
    flags[CLS_SPACE] = en && (lane_byte == BYTE_SPACE);
    flags[CLS_QUOTE] = en && (lane_byte == BYTE_QUOTE);
    flags[CLS_BRACE] = en && ((lane_byte == BYTE_BRACE_OPEN) ||
                              (lane_byte == BYTE_BRACE_CLOSE));
    flags[CLS_COLON] = en && (lane_byte == BYTE_COLON);
    flags[CLS_COMMA] = en && (lane_byte == BYTE_COMMA);
    flags[CLS_HIGH]  = en && lane_byte[7];
  end

endmodule

`default_nettype wire

### design/bczr_merge.sv
// Merging stage: adds the class flags of all byte lanes into per-class increments.
// Depends on bczr_pkg for the flag type and widths.
`default_nettype none

module bczr_merge
  import bczr_pkg::*;
#(
  parameter int LANES = 8
) (
  input  wire class_flags_t      flags [LANES],
  output logic [LANE_CNT_W-1:0]  inc   [NUM_CLASSES]
);

  // Each class sums at most eight single-bit hits.
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      inc[c] = '0;
      for (int l = 0; l < LANES; l++) begin
        inc[c] = inc[c] + LANE_CNT_W'(flags[l][c]);
      end
    end
  end

endmodule

`default_nettype wire

### design/bczr_ppm_div.sv
// Parts per million unit: floor(count * 1000000 / total) by restoring division.
// Multiplies and loads on start, then one quotient bit per cycle; uses bczr_pkg.
`default_nettype none

module bczr_ppm_div
  import bczr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [COUNT_W-1:0] count,
  input  wire logic [COUNT_W-1:0] total,
  output logic                    done,
  output logic [PPM_W-1:0]        ppm
);

  localparam int STEP_W = $clog2(PPM_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PPM_W - 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] den;
  logic [PPM_W-1:0]   sh;
  logic               den_zero;

  logic [PROD_W-1:0]  prod;
  logic [COUNT_W:0]   rem_sh;
  logic               ge;
  logic [COUNT_W-1:0] rem_next;

  // The count never exceeds the total, so the quotient fits in PPM_W bits and
  // the upper product bits start below the divisor.
  assign prod = PROD_W'(count) * PROD_W'(PPM_SCALE);

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh   = {rem, sh[PPM_W-1]};
  assign ge       = rem_sh >= {1'b0, den};
  assign rem_next = ge ? COUNT_W'(rem_sh - {1'b0, den}) : rem_sh[COUNT_W-1:0];

  // Control: busy flag, step counter and the done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and the dividend bits that turn into quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= prod[PROD_W-1:PPM_W];
      sh       <= prod[PPM_W-1:0];
      den      <= total;
      den_zero <= (total == '0);
    end else if (busy) begin
      rem <= rem_next;
      sh  <= {sh[PPM_W-2:0], ge};
    end
  end

  // An empty zone reports zero for every class.
  assign ppm = den_zero ? '0 : sh;

endmodule

`default_nettype wire

### design/byte_class_zone_regime_detector.sv
// Top level of the byte class zone regime detector: lanes, merge, zone counters,
// ppm dividers, delta stage and output register. Depends on bczr_pkg and submodules.
//
// Channel   Signals                              Carries
// input     s_tvalid s_tready s_tdata[71:0]      one chunk of up to eight bytes
// output    m_tvalid m_tready m_tdata[279:0]     one result for each closed zone
// config    cfg_valid cfg_ready cfg_index cfg_data  register writes
//
// An item that does not close a zone is counted in the cycle it is accepted,
// so such items stream at one per cycle.
// An item that closes a zone holds s_tready low through ST_DIV, ST_DELTA and ST_OUT,
// while the six 20-step ppm dividers run and while the output register stays full.
// A result waiting in the output register does not stop the counting of items.
// Synchronous reset clears every counter; the stored previous ratios need none.
`default_nettype none

module byte_class_zone_regime_detector
  import bczr_pkg::*;
#(
  parameter int LANES = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // Fields from bit 0: data[63:0], valid_bytes[67:64], zero fill.
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [IN_TDATA_W-1:0]   s_tdata,
  // Fields from bit 0: zone_index, byte_offset, zone_length, space_ppm, quote_ppm,
  // brace_ppm, colon_ppm, comma_ppm, high_bit_ppm, delta_ppm, event_kind, zero fill.
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [OUT_TDATA_W-1:0]       m_tdata,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    ST_RUN   = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_DELTA = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [ZONE_SIZE_W-1:0] zone_size;
  logic [DELTA_W-1:0]     event_threshold;

  logic [COUNT_W-1:0]  class_counts [NUM_CLASSES];
  logic [COUNT_W-1:0]  zone_byte_count;
  logic [OFFSET_W-1:0] total_offset;
  logic [INDEX_W-1:0]  zone_number;
  logic                have_previous;
  logic [PPM_W-1:0]    prev_ratios [NUM_CLASSES];
  logic [PPM_W-1:0]    abs_diff [NUM_CLASSES];
  logic                div_start;

  logic [DATA_W-1:0]     data;
  logic [LANE_CNT_W-1:0] valid_bytes;
  logic [LANE_CNT_W-1:0] cnt;
  class_flags_t          flags [LANES];
  logic [LANE_CNT_W-1:0] inc [NUM_CLASSES];
  logic [COUNT_W-1:0]    zbc_next;
  logic                  close_zone;
  logic                  accept;
  logic                  out_load;
  logic [NUM_CLASSES-1:0] div_done;
  logic [PPM_W-1:0]      ppm [NUM_CLASSES];
  logic [DELTA_W-1:0]    delta_sum;
  logic [DELTA_W-1:0]    delta;
  logic [KIND_W-1:0]     kind;
  out_item_t             item;

  assign data        = s_tdata[DATA_W-1:0];
  assign valid_bytes = s_tdata[DATA_W +: LANE_CNT_W];
  assign s_tready    = (state == ST_RUN);
  assign accept      = s_tvalid && s_tready;
  assign cfg_ready   = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_size       <= ZONE_SIZE_RST;
      event_threshold <= EVENT_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ZONE_SIZE:       zone_size       <= cfg_data[ZONE_SIZE_W-1:0];
        REG_EVENT_THRESHOLD: event_threshold <= cfg_data[DELTA_W-1:0];
      endcase
    end
  end

  // More valid bytes than lanes counts as a full chunk.
  assign cnt = (valid_bytes > LANE_CNT_W'(LANES)) ? LANE_CNT_W'(LANES) : valid_bytes;

  // Byte lanes, one per byte of the chunk.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    bczr_lane u_lane (
      .lane_byte (data[8*l +: 8]),
      .en        (LANE_CNT_W'(l) < cnt),
      .flags     (flags[l])
    );
  end

  bczr_merge #(.LANES(LANES)) u_merge (
    .flags (flags),
    .inc   (inc)
  );

  // Close test on the byte count including this item.
  assign zbc_next   = zone_byte_count + COUNT_W'(cnt);
  assign close_zone = zbc_next >= {1'b0, zone_size};
  assign out_load   = (state == ST_OUT) && (!m_tvalid || m_tready);

  // Zone counters; they hold still while a closed zone is being evaluated.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) class_counts[c] <= '0;
      zone_byte_count <= '0;
      total_offset    <= '0;
      zone_number     <= '0;
      have_previous   <= 1'b0;
    end else if (accept) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        class_counts[c] <= class_counts[c] + COUNT_W'(inc[c]);
      end
      zone_byte_count <= zbc_next;
      total_offset    <= total_offset + OFFSET_W'(cnt);
    end else if (out_load) begin
      for (int c = 0; c < NUM_CLASSES; c++) class_counts[c] <= '0;
      zone_byte_count <= '0;
      zone_number     <= zone_number + 1'b1;
      have_previous   <= 1'b1;
    end
  end

  // Sequencer for a closing zone.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN:   if (accept && close_zone) state_next = ST_DIV;
      ST_DIV:   if (&div_done) state_next = ST_DELTA;
      ST_DELTA: state_next = ST_OUT;
      ST_OUT:   if (out_load) state_next = ST_RUN;
      default:  state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      div_start <= 1'b0;
    end else begin
      state     <= state_next;
      div_start <= accept && close_zone;
    end
  end

  // One ppm divider per class, all started together.
  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_div
    bczr_ppm_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .count (class_counts[c]),
      .total (zone_byte_count),
      .done  (div_done[c]),
      .ppm   (ppm[c])
    );
  end

  // Absolute differences to the previous zone.
  always_ff @(posedge clk) begin
    if (state == ST_DELTA) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        abs_diff[c] <= (ppm[c] > prev_ratios[c]) ? ppm[c] - prev_ratios[c]
                                                 : prev_ratios[c] - ppm[c];
      end
    end
  end

  // Summed delta and event code.
  always_comb begin
    delta_sum = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      delta_sum = delta_sum + DELTA_W'(abs_diff[c]);
    end
  end

  assign delta = have_previous ? delta_sum : '0;

  always_comb begin
    priority if (!have_previous)         kind = EV_BOOT;
    else if (delta > event_threshold)    kind = EV_REGIME;
    else                                 kind = EV_STABLE;
  end

  // The ratios of this zone become the reference for the next one.
  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int c = 0; c < NUM_CLASSES; c++) prev_ratios[c] <= ppm[c];
    end
  end

  // Result assembly.
  always_comb begin
    item              = '0;
    item.zone_index   = zone_number;
    item.byte_offset  = total_offset;
    item.zone_length  = zone_byte_count;
    item.space_ppm    = ppm[CLS_SPACE];
    item.quote_ppm    = ppm[CLS_QUOTE];
    item.brace_ppm    = ppm[CLS_BRACE];
    item.colon_ppm    = ppm[CLS_COLON];
    item.comma_ppm    = ppm[CLS_COMMA];
    item.high_bit_ppm = ppm[CLS_HIGH];
    item.delta_ppm    = delta;
    item.event_kind   = kind;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= item;
  end

endmodule

`default_nettype wire

### design/bczr_checker.sv
// Port-level checker for the byte class zone regime detector, bound to the top level.
// Depends on bczr_pkg for the result layout and event codes.
`default_nettype none

module bczr_checker
  import bczr_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata
);

  out_item_t item;
  assign item = m_tdata;

  // A stalled result item holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  // The event code is one of the three defined codes.
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (item.event_kind == EV_BOOT) || (item.event_kind == EV_REGIME) ||
                 (item.event_kind == EV_STABLE))
    else $error("undefined event code");

  // The first zone has nothing to compare against.
  a_boot_delta: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (item.event_kind == EV_BOOT) |-> item.delta_ppm == '0)
    else $error("boot item with non-zero delta");

  // A class share cannot exceed one million parts.
  a_ppm_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (item.space_ppm <= PPM_SCALE) && (item.high_bit_ppm <= PPM_SCALE))
    else $error("ppm value above scale");

  // The ratio division runs bit by bit, so a result never follows the item at once.
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared one cycle after an item");

endmodule

bind byte_class_zone_regime_detector bczr_checker u_bczr_checker (.*);

`default_nettype wire

### sim/byte_class_zone_regime_detector_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the byte class zone regime detector.
// Streams byte chunks and register writes, predicts each zone result and checks it.
// Depends on bczr_pkg and the byte_class_zone_regime_detector top level.

module byte_class_zone_regime_detector_test;
  import bczr_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int LANE_LIMIT    = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int SEGMENTS      = 13;
  localparam int SEGMENT_ITEMS = 50;

  typedef enum logic {STEP_CHUNK, STEP_CONFIG} step_kind_t;

  // One row of the opening script: a chunk, or a pair of register values.
  typedef struct {
    step_kind_t         kind;
    logic [63:0]        data;      // chunk bytes, or zone_size for a config row
    logic [3:0]         nbytes;
    logic [DELTA_W-1:0] threshold;
    bit                 pinned;    // zone result below is typed in by hand
    out_item_t          zone;
  } script_step_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // Fields from bit 0: data[63:0], valid_bytes[67:64], zero fill.
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // Fields from bit 0: zone_index, byte_offset, zone_length, six ppm fields,
  // delta_ppm, event_kind, zero fill.
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Predicted state of the detector.
  logic [COUNT_W-1:0]     class_tally [NUM_CLASSES] = '{default: '0};
  logic [COUNT_W-1:0]     zone_fill = '0;
  logic [OFFSET_W-1:0]    bytes_seen = '0;
  logic [INDEX_W-1:0]     zone_no = '0;
  bit                     seen_zone = 1'b0;
  logic [PPM_W-1:0]       last_ppm [NUM_CLASSES] = '{default: '0};
  logic [ZONE_SIZE_W-1:0] zone_limit = ZONE_SIZE_RST;
  logic [DELTA_W-1:0]     regime_level = EVENT_THRESHOLD_RST;

  out_item_t    zones_due [$];
  script_step_t opening_script [$];
  int unsigned  mismatches = 0;
  int           src_idle = 28;
  int           snk_idle = 67;
  bit           hold_req = 1'b0;

  byte_class_zone_regime_detector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Counts one chunk into the predicted zone and returns 1 when the zone closes.
  function automatic bit count_chunk(input logic [63:0] d, input logic [3:0] nb,
                                     output out_item_t z);
    int               n;
    logic [7:0]       b;
    logic [63:0]      scaled;
    logic [DELTA_W-1:0] delta;
    logic [PPM_W-1:0] ppm [NUM_CLASSES];
    z = '0;
    n = (nb > LANE_LIMIT) ? LANE_LIMIT : nb;
    for (int i = 0; i < n; i++) begin
      b = d[8*i +: 8];
      if (b == BYTE_SPACE) class_tally[CLS_SPACE]++;
      if (b == BYTE_QUOTE) class_tally[CLS_QUOTE]++;
      if (b == BYTE_BRACE_OPEN || b == BYTE_BRACE_CLOSE) class_tally[CLS_BRACE]++;
      if (b == BYTE_COLON) class_tally[CLS_COLON]++;
      if (b == BYTE_COMMA) class_tally[CLS_COMMA]++;
      if (b[7]) class_tally[CLS_HIGH]++;
    end
    zone_fill += COUNT_W'(n);
    bytes_seen += OFFSET_W'(n);
    if (zone_fill < zone_limit) return 1'b0;

    // Ratios of the closing zone and their summed distance to the last zone.
    delta = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      scaled = 64'(class_tally[c]) * 64'd1000000;
      ppm[c] = (zone_fill == 0) ? '0 : PPM_W'(scaled / 64'(zone_fill));
      if (seen_zone)
        delta += DELTA_W'((ppm[c] > last_ppm[c]) ? ppm[c] - last_ppm[c]
                                                 : last_ppm[c] - ppm[c]);
    end
    z.zone_index   = zone_no;
    z.byte_offset  = bytes_seen;
    z.zone_length  = zone_fill;
    z.space_ppm    = ppm[CLS_SPACE];
    z.quote_ppm    = ppm[CLS_QUOTE];
    z.brace_ppm    = ppm[CLS_BRACE];
    z.colon_ppm    = ppm[CLS_COLON];
    z.comma_ppm    = ppm[CLS_COMMA];
    z.high_bit_ppm = ppm[CLS_HIGH];
    z.delta_ppm    = delta;
    if (!seen_zone) z.event_kind = EV_BOOT;
    else if (delta > regime_level) z.event_kind = EV_REGIME;
    else z.event_kind = EV_STABLE;

    last_ppm = ppm;
    seen_zone = 1'b1;
    class_tally = '{default: '0};
    zone_fill = '0;
    zone_no++;
    return 1'b1;
  endfunction

  function automatic out_item_t zone_of(input logic [31:0] idx, input logic [63:0] off,
                                        input logic [32:0] zb, input int sp, input int qu,
                                        input int br, input int co, input int cm,
                                        input int hi, input int dl,
                                        input logic [KIND_W-1:0] kind);
    out_item_t z;
    z = '0;
    z.zone_index   = idx;
    z.byte_offset  = off;
    z.zone_length  = zb;
    z.space_ppm    = PPM_W'(sp);
    z.quote_ppm    = PPM_W'(qu);
    z.brace_ppm    = PPM_W'(br);
    z.colon_ppm    = PPM_W'(co);
    z.comma_ppm    = PPM_W'(cm);
    z.high_bit_ppm = PPM_W'(hi);
    z.delta_ppm    = DELTA_W'(dl);
    z.event_kind   = kind;
    return z;
  endfunction

  function automatic void add_chunk(input logic [63:0] d, input logic [3:0] nb);
    script_step_t st;
    st = '{STEP_CHUNK, d, nb, '0, 1'b0, '0};
    opening_script.push_back(st);
  endfunction

  function automatic void add_pinned(input logic [63:0] d, input logic [3:0] nb,
                                     input out_item_t z);
    script_step_t st;
    st = '{STEP_CHUNK, d, nb, '0, 1'b1, z};
    opening_script.push_back(st);
  endfunction

  function automatic void add_config(input logic [31:0] size, input logic [DELTA_W-1:0] thr);
    script_step_t st;
    st = '{STEP_CONFIG, {32'b0, size}, '0, thr, 1'b0, '0};
    opening_script.push_back(st);
  endfunction

  // Class rich bytes, leaning towards one favourite class for the segment.
  function automatic logic [7:0] pick_byte(input int bias, input int fav);
    int roll;
    int cls;
    roll = $urandom_range(99);
    if (roll >= bias) return 8'($urandom);
    cls = (roll < bias / 2) ? fav : $urandom_range(NUM_CLASSES - 1);
    case (cls)
      CLS_SPACE: return BYTE_SPACE;
      CLS_QUOTE: return BYTE_QUOTE;
      CLS_BRACE: return $urandom_range(1) ? BYTE_BRACE_OPEN : BYTE_BRACE_CLOSE;
      CLS_COLON: return BYTE_COLON;
      CLS_COMMA: return BYTE_COMMA;
      default:   return 8'h80 | 8'($urandom);
    endcase
  endfunction

  // Offers one chunk, with a random gap first, and predicts it once accepted.
  task automatic offer_chunk(input logic [63:0] d, input logic [3:0] nb, input bit pinned,
                             input out_item_t pin);
    out_item_t z;
    if ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, nb, d};
    do @(posedge clk); while (!s_tready);
    if (count_chunk(d, nb, z)) zones_due.push_back(pinned ? pin : z);
  endtask

  // Waits for the block to go idle, then writes both registers.
  task automatic program_regs(input logic [31:0] size, input logic [DELTA_W-1:0] thr);
    s_tvalid <= 1'b0;
    while (zones_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ZONE_SIZE;
    cfg_data  <= size;
    do @(posedge clk); while (!cfg_ready);
    zone_limit = size;
    cfg_index <= REG_EVENT_THRESHOLD;
    cfg_data  <= {{(CFG_DATA_W - DELTA_W){1'b0}}, thr};
    do @(posedge clk); while (!cfg_ready);
    regime_level = thr;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result side: checks each accepted result and throttles m_tready.
  initial begin : result_sink
    out_item_t got;
    out_item_t want;
    int        hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = m_tdata;
        if (zones_due.size() == 0) begin
          $display("%0t: unexpected zone result, expected none, got %h", $time, got);
          mismatches++;
        end else begin
          want = zones_due.pop_front();
          check_field("zone_index", 64'(want.zone_index), 64'(got.zone_index));
          check_field("byte_offset", want.byte_offset, got.byte_offset);
          check_field("zone_length", 64'(want.zone_length), 64'(got.zone_length));
          check_field("space_ppm", 64'(want.space_ppm), 64'(got.space_ppm));
          check_field("quote_ppm", 64'(want.quote_ppm), 64'(got.quote_ppm));
          check_field("brace_ppm", 64'(want.brace_ppm), 64'(got.brace_ppm));
          check_field("colon_ppm", 64'(want.colon_ppm), 64'(got.colon_ppm));
          check_field("comma_ppm", 64'(want.comma_ppm), 64'(got.comma_ppm));
          check_field("high_bit_ppm", 64'(want.high_bit_ppm), 64'(got.high_bit_ppm));
          check_field("delta_ppm", 64'(want.delta_ppm), 64'(got.delta_ppm));
          check_field("event_kind", 64'(want.event_kind), 64'(got.event_kind));
          check_field("zero fill", 64'(want.pad), 64'(got.pad));
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  // Ends the run when no item has moved on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    out_item_t          none;
    logic [31:0]        size;
    logic [DELTA_W-1:0] thr;
    logic [63:0]        d;
    logic [3:0]         nb;
    int                 bias;
    int                 fav;
    int                 roll;
    none = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes: the saturating, empty and all-ones chunks close nothing.
    add_chunk(64'h2C3A_7D7B_2220_2020, 4'd15);
    add_chunk(64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
    add_chunk(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    // Lowered zone size: the empty chunk closes the 16 bytes already counted.
    add_config(32'd8, 23'd0);
    add_pinned(64'h2020_2020_2020_2020, 4'd0,
               zone_of(0, 16, 16, 187500, 62500, 125000, 62500, 62500, 500000, 0, EV_BOOT));
    // One pure class per zone, then a repeat and a zone of null bytes with no class hits.
    add_pinned(64'h2020_2020_2020_2020, 4'd8,
               zone_of(1, 24, 8, 1000000, 0, 0, 0, 0, 0, 1625000, EV_REGIME));
    add_pinned(64'h2222_2222_2222_2222, 4'd8,
               zone_of(2, 32, 8, 0, 1000000, 0, 0, 0, 0, 2000000, EV_REGIME));
    add_pinned(64'h7D7B_7D7B_7D7B_7D7B, 4'd8,
               zone_of(3, 40, 8, 0, 0, 1000000, 0, 0, 0, 2000000, EV_REGIME));
    add_pinned(64'h3A3A_3A3A_3A3A_3A3A, 4'd8,
               zone_of(4, 48, 8, 0, 0, 0, 1000000, 0, 0, 2000000, EV_REGIME));
    add_pinned(64'h2C2C_2C2C_2C2C_2C2C, 4'd8,
               zone_of(5, 56, 8, 0, 0, 0, 0, 1000000, 0, 2000000, EV_REGIME));
    add_pinned(64'h8080_FFFF_C0A0_90FF, 4'd8,
               zone_of(6, 64, 8, 0, 0, 0, 0, 0, 1000000, 2000000, EV_REGIME));
    add_pinned(64'h8080_FFFF_C0A0_90FF, 4'd8,
               zone_of(7, 72, 8, 0, 0, 0, 0, 0, 1000000, 0, EV_STABLE));
    add_pinned(64'h0, 4'd8,
               zone_of(8, 80, 8, 0, 0, 0, 0, 0, 0, 1000000, EV_REGIME));
    // Partial chunks; bytes above the valid count must be ignored.
    add_chunk(64'hFFFF_FFFF_2C22_3A20, 4'd4);
    add_chunk(64'h7B20_8022_2C3A_7D41, 4'd9);
    add_chunk(64'h2020_2020_2020_2080, 4'd1);
    add_chunk(64'h2C2C_2C2C_2C7B_22A0, 4'd3);
    add_chunk(64'hFFFF_FF3A_2020_7D22, 4'd5);
    add_chunk(64'h2222_3A3A_2C2C_8181, 4'd6);
    add_chunk(64'h9F20_7B7D_222C_3AE0, 4'd7);
    add_chunk(64'h4141_4141_4141_2C20, 4'd2);
    // Widest zone and highest threshold, then zones of one byte.
    add_config(32'hFFFF_FFFF, 23'd6000000);
    add_chunk(64'hA5A5_2C2C_3A3A_2222, 4'd8);
    add_chunk(64'h5A5A_7D7D_7B7B_2020, 4'd8);
    add_config(32'd1, EVENT_THRESHOLD_RST);
    add_chunk(64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
    add_chunk(64'h0000_0000_0000_0022, 4'd1);
    add_chunk(64'h0000_0000_0000_00F0, 4'd1);

    foreach (opening_script[k]) begin
      if (opening_script[k].kind == STEP_CONFIG)
        program_regs(opening_script[k].data[31:0], opening_script[k].threshold);
      else
        offer_chunk(opening_script[k].data, opening_script[k].nbytes,
                    opening_script[k].pinned, opening_script[k].zone);
    end

    // Random segments, each with its own zone size, threshold and byte mix.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 5) begin
        src_idle = 28;
        snk_idle = 67;
      end else if (seg < 10) begin
        src_idle = 67;
        snk_idle = 28;
      end else begin
        src_idle = 0;
        snk_idle = 0;
      end
      case ($urandom_range(7))
        0:       size = 32'd1;
        1:       size = $urandom_range(100, 400);
        default: size = $urandom_range(2, 48);
      endcase
      case ($urandom_range(4))
        0:       thr = '0;
        1:       thr = 23'd6000000;
        2:       thr = EVENT_THRESHOLD_RST;
        3:       thr = DELTA_W'($urandom_range(0, 6000000));
        default: thr = DELTA_W'($urandom_range(0, 200000));
      endcase
      if (seg == 10) size = $urandom_range(1, 4);
      program_regs(size, thr);
      // Long hold-off on the result side while chunks keep coming.
      if (seg == 10) hold_req = 1'b1;
      bias = $urandom_range(0, 90);
      fav = $urandom_range(NUM_CLASSES - 1);
      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        for (int b = 0; b < 8; b++) d[8*b +: 8] = pick_byte(bias, fav);
        roll = $urandom_range(99);
        if (roll < 3) nb = 4'd0;
        else if (roll < 7) nb = 4'($urandom_range(9, 15));
        else nb = 4'($urandom_range(1, 8));
        offer_chunk(d, nb, 1'b0, none);
      end
    end

    // Drain and report.
    s_tvalid <= 1'b0;
    while (zones_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
